// ===== rtl/timestamp_frame_pick_queue_macros.svh =====
// Assertion macros used by the top-level file to check this block.
// Both macros sample on clk and are switched off while rst_n is low.
`ifndef TIMESTAMP_FRAME_PICK_QUEUE_MACROS_SVH
`define TIMESTAMP_FRAME_PICK_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tfpq_pkg.sv =====
package tfpq_pkg;

    localparam int DEFAULT_DEPTH = 16;

    localparam int OP_W      = 2;
    localparam int TIME_W    = 64;
    localparam int TAG_W     = 32;
    localparam int LIMIT_W   = 5;
    localparam int MARGIN_W  = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [LIMIT_W-1:0]  ACTIVE_LIMIT_RST = 5'd12;
    localparam logic [LIMIT_W-1:0]  IDLE_LIMIT_RST   = 5'd4;
    localparam logic [MARGIN_W-1:0] MARGIN_RST       = 32'd1000000;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_PICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_MODE   = 2'd0,
        REG_ACTIVE_LIMIT  = 2'd1,
        REG_IDLE_LIMIT    = 2'd2,
        REG_REWIND_MARGIN = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_HEAD,
        ST_NEXT,
        ST_DONE
    } state_t;

    // Which queue entry the memory read port fetches.
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_NEXT,
        RD_AFTER
    } rd_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    push_write;
        logic    flush;
        logic    load_limit;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    load_head;
        logic    pop;
        logic    set_found;
        logic    set_seek;
        logic    set_reject;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic empty;
        logic multi;
        logic multi_after_pop;
        logic full;
        logic rewind;
        logic rd_past;
    } dp_status_t;

endpackage

// ===== rtl/timestamp_frame_pick_queue.sv =====
// Queue of decoded frames, each held as a 64-bit timestamp and a 32-bit buffer tag.
// Input words are commands: op, item_time and frame_tag are taken at a rising edge
// where start is high and busy is low. Each command yields one result word, shown
// for exactly one cycle while done is high; the receiver cannot hold it off, so
// done never waits on anything downstream.
// Push, clear, the spare op code and a pick on an empty queue pass from the dispatch
// state straight to the done state. Busy falls at the edge that takes the result,
// and no new word is accepted before that.
// A pick reads the queue through a single memory read port, one entry per cycle.
// It reads the oldest frame first and then, while the walk goes on, each frame
// behind it in turn. Each discarded frame costs one such read, and at most the
// whole queue is walked.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data), taken at
// any edge where cfg_write is high; it should only be used while the block is idle.
// Reset empties the queue and loads the register defaults: idle mode, active limit
// twelve, idle limit four and a rewind margin of one millisecond. The frame memory
// itself is not cleared, as only held entries are ever read.
`include "timestamp_frame_pick_queue_macros.svh"

module timestamp_frame_pick_queue #(
    parameter int QUEUE_DEPTH = tfpq_pkg::DEFAULT_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    output logic                                  done,
    input  logic [tfpq_pkg::OP_W-1:0]             op,
    input  logic [tfpq_pkg::TIME_W-1:0]           item_time,
    input  logic [tfpq_pkg::TAG_W-1:0]            frame_tag,
    input  logic                                  cfg_write,
    input  logic [tfpq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tfpq_pkg::CFG_W-1:0]            cfg_data,
    output logic                                  found,
    output logic [tfpq_pkg::TIME_W-1:0]           shown_time,
    output logic [tfpq_pkg::TAG_W-1:0]            shown_tag,
    output logic                                  seek_request,
    output logic                                  push_rejected,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      fill_level,
    output logic                                  has_room
);
    import tfpq_pkg::*;

    // The controller sequences each command; the datapath holds the queue, the
    // configuration and the result registers, and reports comparisons back.
    dp_cmd_t    cmd;
    dp_status_t status;

    tfpq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tfpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .op            (op),
        .item_time     (item_time),
        .frame_tag     (frame_tag),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .found         (found),
        .shown_time    (shown_time),
        .shown_tag     (shown_tag),
        .seek_request  (seek_request),
        .push_rejected (push_rejected),
        .fill_level    (fill_level),
        .has_room      (has_room)
    );

    // An accepted command must keep the block busy in the following cycle.
    `TFPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    // Every command produces exactly one result word.
    `TFPQ_ASSERT_NEXT(a_single_result, done, !done, "result word repeated")
    // A rewind empties the queue and returns no frame.
    `TFPQ_ASSERT_SAME(a_seek_empty, done && seek_request, fill_level == '0 && !found, "seek left frames")
    // A returned frame stays in the queue and never comes from a push.
    `TFPQ_ASSERT_SAME(a_found_held, done && found, fill_level != '0 && !push_rejected, "shown frame not held")

endmodule

// ===== rtl/tfpq_ctrl.sv =====
module tfpq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  tfpq_pkg::dp_status_t status,
    output tfpq_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import tfpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.op == OP_PICK && !status.empty)
                begin
                    state_next = ST_HEAD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_HEAD:
            begin
                if (!status.rewind && status.rd_past && status.multi)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_NEXT:
            begin
                if (!(status.rd_past && status.multi_after_pop))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd    = '0;
        busy   = (state_reg != ST_IDLE);
        done   = (state_reg == ST_DONE);
        cmd.rd_sel = RD_HEAD;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_item = start;
            end
            ST_DISPATCH:
            begin
                unique case (status.op)
                    OP_PUSH:
                    begin
                        cmd.set_reject = status.full;
                        cmd.push_write = !status.full;
                    end
                    OP_PICK:
                    begin
                        cmd.load_limit = 1'b1;
                        cmd.rd_en      = !status.empty;
                        cmd.rd_sel     = RD_HEAD;
                    end
                    OP_CLEAR:
                    begin
                        cmd.flush = 1'b1;
                    end
                    default:
                    begin
                        cmd.flush = 1'b0;
                    end
                endcase
            end
            ST_HEAD:
            begin
                cmd.load_head = 1'b1;
                if (status.rewind)
                begin
                    cmd.flush    = 1'b1;
                    cmd.set_seek = 1'b1;
                end
                else if (status.rd_past)
                begin
                    if (status.multi)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_NEXT;
                    end
                    else
                    begin
                        cmd.set_found = 1'b1;
                    end
                end
            end
            ST_NEXT:
            begin
                if (status.rd_past)
                begin
                    cmd.pop = 1'b1;
                    if (status.multi_after_pop)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_AFTER;
                    end
                    else
                    begin
                        cmd.set_found = 1'b1;
                    end
                end
                else
                begin
                    cmd.set_found = 1'b1;
                end
            end
            ST_DONE:
            begin
                cmd.load_item = 1'b0;
            end
            default:
            begin
                cmd.load_item = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/tfpq_dp.sv =====
module tfpq_dp #(
    parameter int QUEUE_DEPTH = tfpq_pkg::DEFAULT_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tfpq_pkg::dp_cmd_t                     cmd,
    output tfpq_pkg::dp_status_t                  status,
    input  logic [tfpq_pkg::OP_W-1:0]             op,
    input  logic [tfpq_pkg::TIME_W-1:0]           item_time,
    input  logic [tfpq_pkg::TAG_W-1:0]            frame_tag,
    input  logic                                  cfg_write,
    input  logic [tfpq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tfpq_pkg::CFG_W-1:0]            cfg_data,
    output logic                                  found,
    output logic [tfpq_pkg::TIME_W-1:0]           shown_time,
    output logic [tfpq_pkg::TAG_W-1:0]            shown_tag,
    output logic                                  seek_request,
    output logic                                  push_rejected,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      fill_level,
    output logic                                  has_room
);
    import tfpq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Configuration registers.
    logic                mode_reg;
    logic [LIMIT_W-1:0]  active_limit_reg;
    logic [LIMIT_W-1:0]  idle_limit_reg;
    logic [MARGIN_W-1:0] margin_reg;

    // Queue control.
    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;

    // Latched item and working values.
    op_t               op_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [TIME_W-1:0] limit_reg;
    logic [TIME_W-1:0] cur_time_reg;
    logic [TAG_W-1:0]  cur_tag_reg;
    logic [TIME_W-1:0] rd_time_reg;
    logic [TAG_W-1:0]  rd_tag_reg;
    logic              found_reg;
    logic              seek_reg;
    logic              reject_reg;

    logic [TIME_W-1:0] time_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0]  tag_mem  [QUEUE_DEPTH];

    logic [CNT_W:0]    tail_sum;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W:0]    after_sum;
    logic [IDX_W-1:0]  next_idx;
    logic [IDX_W-1:0]  after_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W:0]   margin_sum;
    logic [LIMIT_W-1:0] sel_limit;
    logic [LIM_W-1:0]  eff_limit;
    logic [LIM_W-1:0]  count_ext;

    assign tail_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign wr_addr  = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                    ? IDX_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH))
                    : IDX_W'(tail_sum);

    assign next_idx  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign after_sum = (IDX_W+1)'(head_reg) + (IDX_W+1)'(2);
    assign after_idx = (after_sum >= (IDX_W+1)'(QUEUE_DEPTH))
                     ? IDX_W'(after_sum - (IDX_W+1)'(QUEUE_DEPTH))
                     : IDX_W'(after_sum);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD:  rd_addr = head_reg;
            RD_NEXT:  rd_addr = next_idx;
            RD_AFTER: rd_addr = after_idx;
            default:  rd_addr = head_reg;
        endcase
    end

    // The limit is the selected register clamped to the queue depth.
    assign sel_limit = mode_reg ? active_limit_reg : idle_limit_reg;
    assign eff_limit = (LIM_W'(sel_limit) > LIM_W'(QUEUE_DEPTH))
                     ? LIM_W'(QUEUE_DEPTH) : LIM_W'(sel_limit);
    assign count_ext = LIM_W'(count_reg);

    // Wanted time plus margin, saturating at the top of the time range.
    assign margin_sum = (TIME_W+1)'(time_reg) + (TIME_W+1)'(margin_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= 1'b0;
            active_limit_reg <= ACTIVE_LIMIT_RST;
            idle_limit_reg   <= IDLE_LIMIT_RST;
            margin_reg       <= MARGIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_MODE:   mode_reg         <= cfg_data[0];
                REG_ACTIVE_LIMIT:  active_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_IDLE_LIMIT:    idle_limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_REWIND_MARGIN: margin_reg       <= cfg_data[MARGIN_W-1:0];
                default:           mode_reg         <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            op_reg     <= OP_NOP;
            found_reg  <= 1'b0;
            seek_reg   <= 1'b0;
            reject_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                op_reg     <= op_t'(op);
                found_reg  <= 1'b0;
                seek_reg   <= 1'b0;
                reject_reg <= 1'b0;
            end
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.set_seek)
            begin
                seek_reg <= 1'b1;
            end
            if (cmd.set_reject)
            begin
                reject_reg <= 1'b1;
            end
            if (cmd.flush)
            begin
                head_reg  <= '0;
                count_reg <= '0;
            end
            else if (cmd.push_write)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                head_reg  <= next_idx;
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            time_reg <= item_time;
            tag_reg  <= frame_tag;
        end
        if (cmd.load_limit)
        begin
            limit_reg <= margin_sum[TIME_W] ? '1 : margin_sum[TIME_W-1:0];
        end
        if (cmd.load_head || cmd.pop)
        begin
            cur_time_reg <= rd_time_reg;
            cur_tag_reg  <= rd_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_write)
        begin
            time_mem[wr_addr] <= time_reg;
            tag_mem[wr_addr]  <= tag_reg;
        end
        if (cmd.rd_en)
        begin
            rd_time_reg <= time_mem[rd_addr];
            rd_tag_reg  <= tag_mem[rd_addr];
        end
    end

    assign status.op              = op_reg;
    assign status.empty           = (count_reg == '0);
    assign status.multi           = (count_reg > CNT_W'(1));
    assign status.multi_after_pop = (count_reg > CNT_W'(2));
    assign status.full            = (count_ext >= eff_limit)
                                 || (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign status.rewind          = (limit_reg < rd_time_reg);
    assign status.rd_past         = (rd_time_reg <= time_reg);

    assign found         = found_reg;
    assign shown_time    = found_reg ? cur_time_reg : '0;
    assign shown_tag     = found_reg ? cur_tag_reg : '0;
    assign seek_request  = seek_reg;
    assign push_rejected = reject_reg;
    assign fill_level    = count_reg;
    assign has_room      = (count_ext < eff_limit);

endmodule

// ===== tb/timestamp_frame_pick_queue_tb.sv =====
module timestamp_frame_pick_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tfpq_pkg::*;

    localparam int DEPTH       = tfpq_pkg::DEFAULT_DEPTH;
    localparam int FILL_W      = $clog2(DEPTH + 1);
    localparam int HIGH_NS     = 5;
    localparam int LOW_NS      = 5;
    localparam int RESET_CYC   = 12;
    localparam int NUM_PHASES  = 11;
    localparam int CYCLE_LIMIT = 400000;

    // One result word as the block presents it on its result ports.
    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] shown_time;
        logic [TAG_W-1:0]  shown_tag;
        logic              seek_request;
        logic              push_rejected;
        logic [FILL_W-1:0] fill_level;
        logic              has_room;
    } frame_outcome_t;

    // One row of the directed table. Where typed is set, want holds the
    // result written out by hand; otherwise the predictor supplies it.
    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] t;
        logic [TAG_W-1:0]  tag;
        logic              typed;
        frame_outcome_t    want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 done;
    logic [OP_W-1:0]      op = OP_NOP;
    logic [TIME_W-1:0]    item_time = '0;
    logic [TAG_W-1:0]     frame_tag = '0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 found;
    logic [TIME_W-1:0]    shown_time;
    logic [TAG_W-1:0]     shown_tag;
    logic                 seek_request;
    logic                 push_rejected;
    logic [FILL_W-1:0]    fill_level;
    logic                 has_room;

    timestamp_frame_pick_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .op            (op),
        .item_time     (item_time),
        .frame_tag     (frame_tag),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .found         (found),
        .shown_time    (shown_time),
        .shown_tag     (shown_tag),
        .seek_request  (seek_request),
        .push_rejected (push_rejected),
        .fill_level    (fill_level),
        .has_room      (has_room)
    );

    // The clock runs from time zero; every input above already holds a
    // known value, so nothing floats while reset is low.
    always
    begin
        #(LOW_NS) clk = 1'b1;
        #(HIGH_NS) clk = 1'b0;
    end

    // The predictor's own copy of the frame queue and of the registers.
    // The registers start at their reset values.
    logic [TIME_W-1:0] q_time [DEPTH];
    logic [TAG_W-1:0]  q_tag  [DEPTH];
    int unsigned       q_head = 0;
    int unsigned       q_count = 0;
    logic              cur_mode = 1'b0;
    int unsigned       cur_active_limit = 32'(ACTIVE_LIMIT_RST);
    int unsigned       cur_idle_limit = 32'(IDLE_LIMIT_RST);
    logic [MARGIN_W-1:0] cur_margin = MARGIN_RST;

    // Results that the block still owes us, oldest first.
    frame_outcome_t pending_outcomes [$];
    stim_row_t      directed_table [$];

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // Pacing of the sender: words go out in bursts, and between bursts the
    // sender falls silent for a random number of cycles unless idling is
    // switched off for the current phase.
    int unsigned burst_left = 0;
    logic        idling = 1'b1;

    // Works out the result of one command word and moves the predictor's
    // queue on accordingly. The pick first looks for a rewind against the
    // oldest frame, then drops past frames from the head for as long as the
    // next one is past as well, and reports the head frame, if past, without removing it.
    function automatic frame_outcome_t frame_queue_outcome(op_t o, logic [TIME_W-1:0] t,
                                                           logic [TAG_W-1:0] tg);
        frame_outcome_t    res;
        int unsigned       lim;
        logic [TIME_W:0]   reach;
        logic [TIME_W-1:0] horizon;
        logic              walking;
        res = '0;
        lim = cur_mode ? cur_active_limit : cur_idle_limit;
        if (lim > DEPTH)
            lim = DEPTH;
        case (o)
            OP_PUSH:
            begin
                if (q_count >= lim)
                    res.push_rejected = 1'b1;
                else
                begin
                    q_time[(q_head + q_count) % DEPTH] = t;
                    q_tag[(q_head + q_count) % DEPTH]  = tg;
                    q_count++;
                end
            end
            OP_PICK:
            begin
                // The wanted time plus the margin saturates rather than wraps.
                reach   = {1'b0, t} + {{(TIME_W + 1 - MARGIN_W){1'b0}}, cur_margin};
                horizon = reach[TIME_W] ? {TIME_W{1'b1}} : reach[TIME_W-1:0];
                if (q_count > 0 && horizon < q_time[q_head])
                begin
                    q_head = 0;
                    q_count = 0;
                    res.seek_request = 1'b1;
                end
                walking = 1'b1;
                while (walking && q_count > 0 && q_time[q_head] <= t)
                begin
                    if (q_count > 1 && q_time[(q_head + 1) % DEPTH] <= t)
                    begin
                        q_head = (q_head + 1) % DEPTH;
                        q_count--;
                    end
                    else
                    begin
                        res.found      = 1'b1;
                        res.shown_time = q_time[q_head];
                        res.shown_tag  = q_tag[q_head];
                        walking = 1'b0;
                    end
                end
            end
            OP_CLEAR:
            begin
                q_head = 0;
                q_count = 0;
            end
            default:
            begin
            end
        endcase
        res.fill_level = q_count[FILL_W-1:0];
        res.has_room   = (q_count < lim);
        return res;
    endfunction

    function automatic frame_outcome_t typed_outcome(int unsigned f, int unsigned st,
                                                     int unsigned sg, int unsigned sk,
                                                     int unsigned rj, int unsigned fill,
                                                     int unsigned rm);
        frame_outcome_t res;
        res.found         = 1'(f);
        res.shown_time    = TIME_W'(st);
        res.shown_tag     = TAG_W'(sg);
        res.seek_request  = 1'(sk);
        res.push_rejected = 1'(rj);
        res.fill_level    = fill[FILL_W-1:0];
        res.has_room      = 1'(rm);
        return res;
    endfunction

    task automatic add_row(op_t o, logic [TIME_W-1:0] t, logic [TAG_W-1:0] tg,
                           logic typed, frame_outcome_t want);
        stim_row_t r;
        r.op    = o;
        r.t     = t;
        r.tag   = tg;
        r.typed = typed;
        r.want  = want;
        directed_table.insert(directed_table.size(), r);
    endtask

    function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Presents one command word and holds it until the block takes it. All
    // inputs change at the falling edge; busy is looked at on the rising edge,
    // before the block has updated it, so the word is taken exactly when the
    // block sees start high and busy low. Start stays high when the next word
    // follows straight on, so it is never lowered and raised in one step.
    task automatic send_word(op_t o, logic [TIME_W-1:0] t, logic [TAG_W-1:0] tg,
                             logic typed, frame_outcome_t want);
        frame_outcome_t predicted;
        int unsigned    gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = idling ? $urandom_range(0, 25) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        start     = 1'b1;
        op        = o;
        item_time = t;
        frame_tag = tg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = frame_queue_outcome(o, t, tg);
        pending_outcomes.insert(pending_outcomes.size(), typed ? want : predicted);
    endtask

    // Lowers start and lets the block run dry: every owed result has come
    // and busy has dropped. Registers may only be written after this.
    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending_outcomes.size() != 0 || busy)
            @(negedge clk);
    endtask

    // A register write takes effect at the rising edge inside the write
    // pulse; the predictor's copy is updated when the pulse ends, masked to
    // the register's width as the block does.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_ACTIVE_MODE:   cur_mode = data[0];
            REG_ACTIVE_LIMIT:  cur_active_limit = 32'(data[LIMIT_W-1:0]);
            REG_IDLE_LIMIT:    cur_idle_limit = 32'(data[LIMIT_W-1:0]);
            REG_REWIND_MARGIN: cur_margin = data[MARGIN_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    // Every result word is on the ports for exactly one cycle with done high,
    // and is taken at the rising edge that closes that cycle. The receiver
    // cannot hold results off, so it simply checks each one as it passes.
    always @(posedge clk)
    begin : result_check
        frame_outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t ns: result word with none expected, actual fill %0d found %0b",
                         $time, fill_level, found);
                mismatches++;
            end
            else
            begin
                want = pending_outcomes[0];
                pending_outcomes.delete(0);
                check_field("found", TIME_W'(want.found), TIME_W'(found));
                check_field("shown_time", want.shown_time, shown_time);
                check_field("shown_tag", TIME_W'(want.shown_tag), TIME_W'(shown_tag));
                check_field("seek_request", TIME_W'(want.seek_request),
                            TIME_W'(seek_request));
                check_field("push_rejected", TIME_W'(want.push_rejected),
                            TIME_W'(push_rejected));
                check_field("fill_level", TIME_W'(want.fill_level), TIME_W'(fill_level));
                check_field("has_room", TIME_W'(want.has_room), TIME_W'(has_room));
            end
        end
    end

    // Watchdog: a hung handshake or a result that never comes ends the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: cycle limit reached, %0d results still owed",
                     $time, pending_outcomes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] next_push;
        logic [TIME_W-1:0] play_t;
        logic [TIME_W-1:0] wanted;
        logic              m;
        int unsigned       act_lim;
        int unsigned       idle_lim;
        logic [CFG_W-1:0]  margin;
        int unsigned       iv;
        int unsigned       n_items;
        int unsigned       r;
        int unsigned       sel;
        frame_outcome_t    none;

        none = '0;

        // The directed table runs with the registers at their reset values:
        // idle mode, so the idle limit of four applies, and a margin of one
        // millisecond. Frames may be pushed out of time order; the queue
        // keeps them in arrival order regardless.
        add_row(OP_PICK, 64'd0, 32'hFFFF_FFFF, 1'b1, typed_outcome(0, 0, 0, 0, 0, 0, 1));
        add_row(OP_CLEAR, 64'd0, 32'd0, 1'b1, typed_outcome(0, 0, 0, 0, 0, 0, 1));
        add_row(OP_NOP, {TIME_W{1'b1}}, 32'hFFFF_FFFF, 1'b1,
                typed_outcome(0, 0, 0, 0, 0, 0, 1));
        add_row(OP_PUSH, 64'd100, 32'hFFFF_FFFF, 1'b1, typed_outcome(0, 0, 0, 0, 0, 1, 1));
        add_row(OP_PUSH, 64'd0, 32'd0, 1'b0, none);
        add_row(OP_PUSH, 64'd2000, 32'h0000_1234, 1'b0, none);
        add_row(OP_PUSH, {TIME_W{1'b1}}, 32'hA5A5_A5A5, 1'b1,
                typed_outcome(0, 0, 0, 0, 0, 4, 0));
        // The queue is now at its limit, so this push is refused.
        add_row(OP_PUSH, 64'd5, 32'd1, 1'b1, typed_outcome(0, 0, 0, 0, 1, 4, 0));
        // At time 50 nothing is past yet: no frame, no rewind.
        add_row(OP_PICK, 64'd50, 32'd0, 1'b0, none);
        add_row(OP_PICK, 64'd100, 32'd0, 1'b0, none);
        add_row(OP_PICK, 64'd2000, 32'd0, 1'b0, none);
        add_row(OP_PICK, {TIME_W{1'b1}}, 32'd0, 1'b0, none);
        // The oldest frame lies far beyond time zero plus the margin: rewind.
        add_row(OP_PICK, 64'd0, 32'd0, 1'b1, typed_outcome(0, 0, 0, 1, 0, 0, 1));
        // A wanted time just below the top saturates when the margin is added,
        // so a frame at the very top is not taken as a rewind.
        add_row(OP_PUSH, {TIME_W{1'b1}}, 32'h0F0F_0F0F, 1'b0, none);
        add_row(OP_PICK, 64'hFFFF_FFFF_FFFF_FFF6, 32'd0, 1'b0, none);
        add_row(OP_CLEAR, 64'd0, 32'd0, 1'b1, typed_outcome(0, 0, 0, 0, 0, 0, 1));
        // Exactly at the margin is still fine; one nanosecond more rewinds.
        add_row(OP_PUSH, 64'd1000100, 32'd3, 1'b0, none);
        add_row(OP_PICK, 64'd100, 32'd0, 1'b0, none);
        add_row(OP_PICK, 64'd99, 32'd0, 1'b1, typed_outcome(0, 0, 0, 1, 0, 0, 1));
        // The spare op code leaves a non-empty queue alone.
        add_row(OP_PUSH, 64'd7, 32'h8000_0000, 1'b0, none);
        add_row(OP_NOP, 64'd0, 32'd0, 1'b0, none);
        add_row(OP_PICK, 64'd7, 32'd0, 1'b0, none);
        add_row(OP_CLEAR, 64'd0, 32'd0, 1'b1, typed_outcome(0, 0, 0, 0, 0, 0, 1));

        // Reset is asserted once, from time zero, and released on a falling
        // edge so that it never coincides with a sampling edge.
        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_table[k])
            send_word(directed_table[k].op, directed_table[k].t, directed_table[k].tag,
                      directed_table[k].typed, directed_table[k].want);

        // Random part, in phases. Each phase starts with the block drained,
        // writes all four registers, and then plays a stream of frames: a
        // decoder pushing frames at a steady interval and a display picking
        // for a wanted time that moves forward, with occasional jumps back,
        // clears, spare op codes and words with random content.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    m = 1'b1; act_lim = 16; idle_lim = 4; margin = 32'd1000000;
                end
                1:
                begin
                    m = 1'b0; act_lim = 12; idle_lim = 1; margin = 32'd0;
                end
                2:
                begin
                    m = 1'b1; act_lim = 31; idle_lim = 16; margin = 32'hFFFF_FFFF;
                end
                3:
                begin
                    m = 1'b0; act_lim = 0; idle_lim = 17; margin = $urandom;
                end
                4:
                begin
                    m = 1'b1; act_lim = 0; idle_lim = 5; margin = 32'd1000000;
                end
                5:
                begin
                    m = 1'b0; act_lim = 16; idle_lim = 0; margin = 32'd500000;
                end
                default:
                begin
                    m = 1'($urandom_range(0, 1));
                    act_lim  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(1, 16);
                    idle_lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(1, 16);
                    margin   = ($urandom_range(0, 2) == 0) ? $urandom
                                                           : $urandom_range(0, 20000000);
                end
            endcase
            // The upper bits of the narrow registers carry noise; only the
            // register's own width may matter.
            write_reg(REG_ACTIVE_MODE, {31'($urandom), m});
            write_reg(REG_ACTIVE_LIMIT, ($urandom & ~32'h1F) | act_lim);
            write_reg(REG_IDLE_LIMIT, ($urandom & ~32'h1F) | idle_lim);
            write_reg(REG_REWIND_MARGIN, margin);

            idling  = (p % 3 != 1);
            n_items = (p == 4 || p == 5) ? 40 : 125;
            iv      = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 1000)
                                                  : $urandom_range(1000, 4000000);
            case ($urandom_range(0, 3))
                0:       base = {$urandom, $urandom};
                1:       base = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 50000000));
                default: base = {32'd0, $urandom};
            endcase
            next_push = base;
            play_t    = base;

            for (int i = 0; i < n_items; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    send_word(OP_PUSH, next_push, $urandom, 1'b0, none);
                    next_push = next_push + TIME_W'($urandom_range(iv / 2 + 1, iv + iv / 2));
                end
                else if (r < 80)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                    begin
                        // A jump back past the margin, as when the user seeks.
                        wanted = play_t - TIME_W'(cur_margin)
                                 - TIME_W'($urandom_range(1, 2 * iv));
                        play_t    = wanted;
                        next_push = wanted;
                    end
                    else if (sel == 1 && q_count > 0)
                    begin
                        // Aim at the oldest frame itself or right at the edge of
                        // the rewind margin in front of it.
                        case ($urandom_range(0, 2))
                            0:       wanted = q_time[q_head];
                            1:       wanted = q_time[q_head] - TIME_W'(cur_margin);
                            default: wanted = q_time[q_head] - TIME_W'(cur_margin) - 1;
                        endcase
                    end
                    else
                    begin
                        play_t = play_t + TIME_W'($urandom_range(0, 2 * iv));
                        wanted = play_t;
                    end
                    send_word(OP_PICK, wanted, $urandom, 1'b0, none);
                end
                else if (r < 86)
                begin
                    send_word(OP_CLEAR, {$urandom, $urandom}, $urandom, 1'b0, none);
                    next_push = play_t;
                end
                else if (r < 89)
                    send_word(OP_NOP, {$urandom, $urandom}, $urandom, 1'b0, none);
                else if ($urandom_range(0, 1) == 0)
                    send_word(OP_PUSH, {$urandom, $urandom}, $urandom, 1'b0, none);
                else
                    send_word(OP_PICK, {$urandom, $urandom}, $urandom, 1'b0, none);

                // Now and then the sender holds back until every result is in.
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
        end

        // All words are in. Wait for the last results, then a little longer
        // than the longest pick, so that a stray extra result is still seen.
        wait_drained();
        repeat (DEPTH + 8) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== timestamp_frame_pick_queue.f =====
+incdir+rtl
rtl/tfpq_pkg.sv
rtl/tfpq_ctrl.sv
rtl/tfpq_dp.sv
rtl/timestamp_frame_pick_queue.sv
tb/timestamp_frame_pick_queue_tb.sv
